// ----- hdl/qpr_pkg.sv -----
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared widths, register indexes and beat types of the quaternion point
// rotator.
// ----------------------------------------------------------------------------
package qpr_pkg;

  localparam int QPR_CW     = 32;          // coordinate width, Q(CW-16).16
  localparam int QPR_QW     = 32;          // quaternion word width, Q2.30
  localparam int QPR_QH     = QPR_QW / 2;  // split point of a quaternion word
  localparam int QPR_Q_FRAC = 30;
  localparam int QPR_P_FRAC = 16;

  localparam logic signed [QPR_QW-1:0] QPR_ROT_V_RST = '0;
  localparam logic signed [QPR_QW-1:0] QPR_ROT_W_RST = QPR_QW'(1) <<< QPR_Q_FRAC;

  typedef enum logic [1:0] {
    REG_ROT_X = 2'd0,
    REG_ROT_Y = 2'd1,
    REG_ROT_Z = 2'd2,
    REG_ROT_W = 2'd3
  } qpr_reg_t;

  typedef struct packed {
    logic signed [QPR_CW-1:0] pt_x;
    logic signed [QPR_CW-1:0] pt_y;
    logic signed [QPR_CW-1:0] pt_z;
  } qpr_in_t;

  typedef struct packed {
    logic signed [QPR_CW-1:0] out_x;
    logic signed [QPR_CW-1:0] out_y;
    logic signed [QPR_CW-1:0] out_z;
    logic                     clipped;
  } qpr_out_t;

endpackage

// ----- hdl/qpr_dot.sv -----
// ----------------------------------------------------------------------------
// qpr_dot
// Two-stage signed dot product of N terms against quaternion words, with
// fixed term signs and round-to-nearest right shift of the sum.
// ----------------------------------------------------------------------------
module qpr_dot import qpr_pkg::*; #(
  parameter int           N     = 3,
  parameter int           AW    = QPR_CW,
  parameter int           SHIFT = QPR_P_FRAC,
  parameter int           OW    = QPR_CW + 18,
  parameter logic [N-1:0] NEG   = '0
) (
  input  logic                  clk,
  input  logic                  en1,
  input  logic                  en2,
  input  logic [N-1:0][AW-1:0]  a,
  input  logic [N-1:0][QPR_QW-1:0] b,
  output logic signed [OW-1:0]  y
);

  // partial product width: a times 17-bit signed half word
  localparam int PW = AW + QPR_QH + 1;
  // exact sum width with headroom for N terms
  localparam int SW = AW + QPR_QW + $clog2(N) + 2;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (SHIFT - 1);

  logic signed [PW-1:0] ph_r [N];
  logic signed [PW-1:0] pl_r [N];
  logic signed [PW-1:0] ph_nxt [N];
  logic signed [PW-1:0] pl_nxt [N];
  logic signed [SW-1:0] hs, ls, tot, rnd;
  logic signed [OW-1:0] y_r, y_nxt;

  // high half signed, low half zero-extended
  always_comb begin
    for (int k = 0; k < N; k++) begin
      ph_nxt[k] = $signed(a[k]) * $signed(b[k][QPR_QW-1:QPR_QH]);
      pl_nxt[k] = $signed(a[k]) * $signed({1'b0, b[k][QPR_QH-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < N; k++) begin
        ph_r[k] <= ph_nxt[k];
        pl_r[k] <= pl_nxt[k];
      end
    end
  end

  always_comb begin
    hs = '0;
    ls = '0;
    for (int k = 0; k < N; k++) begin
      if (NEG[k]) begin
        hs = hs - ph_r[k];
        ls = ls - pl_r[k];
      end else begin
        hs = hs + ph_r[k];
        ls = ls + pl_r[k];
      end
    end
    tot   = (hs <<< QPR_QH) + ls;
    rnd   = tot + RND;
    y_nxt = OW'(rnd >>> SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

// ----- hdl/quaternion_point_rotator.sv -----
// ----------------------------------------------------------------------------
// quaternion_point_rotator
// Rotates one Q16.16 point per beat by the loaded quaternion q, as
// q * (p,0) * conj(q), with rounding, saturation and a clip flag.
// ----------------------------------------------------------------------------
// Takes one point per clock while no stall backs up to the input. The four
// pipeline stages are the two quaternion products, each split into a
// partial-product register (24 multipliers of 17 bits by the operand width)
// and a sum-and-round register; the last sum register is the output register
// and saturation sits after it. Stalls back up one stage at a time, so empty
// stages fill while the output waits. q is used as loaded, not normalized; a
// non-unit q scales the point by |q|^2. Load rot_x..rot_z with axis times
// sin(angle/2) and rot_w with cos(angle/2) in Q2.30, only while the pipeline
// is empty.
// ----------------------------------------------------------------------------
module quaternion_point_rotator import qpr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // point beats
  input  logic              in_valid,
  output logic              in_stall,
  input  qpr_in_t           in_data,
  // result beats
  output logic              out_valid,
  input  logic              out_stall,
  output qpr_out_t          out_data,
  // register writes
  input  logic              cfg_wr_en,
  input  qpr_reg_t          cfg_index,
  input  logic [QPR_QW-1:0] cfg_wdata
);

  localparam int CW      = QPR_CW;
  localparam int R_SHIFT = QPR_P_FRAC;                       // q*p: 46 -> 30 frac
  localparam int S_SHIFT = 2 * QPR_Q_FRAC - QPR_P_FRAC;      // r*q': 60 -> 16 frac
  localparam int RW      = CW + QPR_QW + 2 - R_SHIFT;        // width of r parts
  localparam int SOW     = RW + QPR_QW + 3 - S_SHIFT;        // rounded s width

  // --------------------------------------------------------------------------
  // Rotation registers
  // --------------------------------------------------------------------------
  logic signed [QPR_QW-1:0] rot_x_r, rot_y_r, rot_z_r, rot_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= QPR_ROT_V_RST;
      rot_y_r <= QPR_ROT_V_RST;
      rot_z_r <= QPR_ROT_V_RST;
      rot_w_r <= QPR_ROT_W_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROT_X: rot_x_r <= cfg_wdata;
        REG_ROT_Y: rot_y_r <= cfg_wdata;
        REG_ROT_Z: rot_z_r <= cfg_wdata;
        REG_ROT_W: rot_w_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: A = q*p partials, B = r, C = r*q' partials, D = output.
  // A stage loads when it is empty or the stage after it moves.
  // --------------------------------------------------------------------------
  logic va_r, vb_r, vc_r, vd_r;
  logic va_nxt, vb_nxt, vc_nxt, vd_nxt;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d = !vd_r || !out_stall;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;

  always_comb begin
    va_nxt = rdy_a ? in_valid : va_r;
    vb_nxt = rdy_b ? va_r     : vb_r;
    vc_nxt = rdy_c ? vb_r     : vc_r;
    vd_nxt = rdy_d ? vc_r     : vd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
      vd_r <= vd_nxt;
    end
  end

  assign in_stall  = !rdy_a;
  assign out_valid = vd_r;

  // --------------------------------------------------------------------------
  // r = q * (p, 0)
  //   r0 = w*px + y*pz - z*py     r1 = w*py - x*pz + z*px
  //   r2 = w*pz + x*py - y*px     r3 = -(x*px + y*py + z*pz)
  // --------------------------------------------------------------------------
  logic [2:0][CW-1:0]     r0_a, r1_a, r2_a, r3_a;
  logic [2:0][QPR_QW-1:0] r0_b, r1_b, r2_b, r3_b;
  logic signed [RW-1:0]   r0, r1, r2, r3;

  assign r0_a[0] = in_data.pt_x;  assign r0_b[0] = rot_w_r;
  assign r0_a[1] = in_data.pt_z;  assign r0_b[1] = rot_y_r;
  assign r0_a[2] = in_data.pt_y;  assign r0_b[2] = rot_z_r;

  assign r1_a[0] = in_data.pt_y;  assign r1_b[0] = rot_w_r;
  assign r1_a[1] = in_data.pt_z;  assign r1_b[1] = rot_x_r;
  assign r1_a[2] = in_data.pt_x;  assign r1_b[2] = rot_z_r;

  assign r2_a[0] = in_data.pt_z;  assign r2_b[0] = rot_w_r;
  assign r2_a[1] = in_data.pt_y;  assign r2_b[1] = rot_x_r;
  assign r2_a[2] = in_data.pt_x;  assign r2_b[2] = rot_y_r;

  assign r3_a[0] = in_data.pt_x;  assign r3_b[0] = rot_x_r;
  assign r3_a[1] = in_data.pt_y;  assign r3_b[1] = rot_y_r;
  assign r3_a[2] = in_data.pt_z;  assign r3_b[2] = rot_z_r;

  qpr_dot #(.N(3), .AW(CW), .SHIFT(R_SHIFT), .OW(RW), .NEG(3'b100)) u_r0 (
    .clk(clk), .en1(rdy_a), .en2(rdy_b), .a(r0_a), .b(r0_b), .y(r0));
  qpr_dot #(.N(3), .AW(CW), .SHIFT(R_SHIFT), .OW(RW), .NEG(3'b010)) u_r1 (
    .clk(clk), .en1(rdy_a), .en2(rdy_b), .a(r1_a), .b(r1_b), .y(r1));
  qpr_dot #(.N(3), .AW(CW), .SHIFT(R_SHIFT), .OW(RW), .NEG(3'b100)) u_r2 (
    .clk(clk), .en1(rdy_a), .en2(rdy_b), .a(r2_a), .b(r2_b), .y(r2));
  qpr_dot #(.N(3), .AW(CW), .SHIFT(R_SHIFT), .OW(RW), .NEG(3'b111)) u_r3 (
    .clk(clk), .en1(rdy_a), .en2(rdy_b), .a(r3_a), .b(r3_b), .y(r3));

  // --------------------------------------------------------------------------
  // s = r * conj(q), vector part only
  //   s0 = r0*w - r3*x - r1*z + r2*y
  //   s1 = r1*w - r3*y + r0*z - r2*x
  //   s2 = r2*w - r3*z - r0*y + r1*x
  // --------------------------------------------------------------------------
  logic [3:0][RW-1:0]     s0_a, s1_a, s2_a;
  logic [3:0][QPR_QW-1:0] s0_b, s1_b, s2_b;
  logic signed [SOW-1:0]  s0, s1, s2;

  assign s0_a[0] = r0;  assign s0_b[0] = rot_w_r;
  assign s0_a[1] = r3;  assign s0_b[1] = rot_x_r;
  assign s0_a[2] = r1;  assign s0_b[2] = rot_z_r;
  assign s0_a[3] = r2;  assign s0_b[3] = rot_y_r;

  assign s1_a[0] = r1;  assign s1_b[0] = rot_w_r;
  assign s1_a[1] = r3;  assign s1_b[1] = rot_y_r;
  assign s1_a[2] = r0;  assign s1_b[2] = rot_z_r;
  assign s1_a[3] = r2;  assign s1_b[3] = rot_x_r;

  assign s2_a[0] = r2;  assign s2_b[0] = rot_w_r;
  assign s2_a[1] = r3;  assign s2_b[1] = rot_z_r;
  assign s2_a[2] = r0;  assign s2_b[2] = rot_y_r;
  assign s2_a[3] = r1;  assign s2_b[3] = rot_x_r;

  qpr_dot #(.N(4), .AW(RW), .SHIFT(S_SHIFT), .OW(SOW), .NEG(4'b0110)) u_s0 (
    .clk(clk), .en1(rdy_c), .en2(rdy_d), .a(s0_a), .b(s0_b), .y(s0));
  qpr_dot #(.N(4), .AW(RW), .SHIFT(S_SHIFT), .OW(SOW), .NEG(4'b1010)) u_s1 (
    .clk(clk), .en1(rdy_c), .en2(rdy_d), .a(s1_a), .b(s1_b), .y(s1));
  qpr_dot #(.N(4), .AW(RW), .SHIFT(S_SHIFT), .OW(SOW), .NEG(4'b0110)) u_s2 (
    .clk(clk), .en1(rdy_c), .en2(rdy_d), .a(s2_a), .b(s2_b), .y(s2));

  // --------------------------------------------------------------------------
  // Saturation off the output register; held stable while stalled.
  // --------------------------------------------------------------------------
  function automatic logic fits(input logic signed [SOW-1:0] v);
    fits = (&v[SOW-1:CW-1]) || !(|v[SOW-1:CW-1]);
  endfunction

  function automatic logic [CW-1:0] clamp(input logic signed [SOW-1:0] v);
    if (fits(v)) begin
      clamp = v[CW-1:0];
    end else if (v[SOW-1]) begin
      clamp = {1'b1, {(CW-1){1'b0}}};
    end else begin
      clamp = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  always_comb begin
    out_data.out_x   = clamp(s0);
    out_data.out_y   = clamp(s1);
    out_data.out_z   = clamp(s2);
    out_data.clipped = !(fits(s0) && fits(s1) && fits(s2));
  end

endmodule

// ----- hdl/qpr_checker.sv -----
// ----------------------------------------------------------------------------
// qpr_checker
// Port-level checks of the quaternion point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module qpr_checker import qpr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input qpr_out_t          out_data
);

  localparam logic signed [QPR_CW-1:0] C_MAX = {1'b0, {(QPR_CW-1){1'b1}}};
  localparam logic signed [QPR_CW-1:0] C_MIN = {1'b1, {(QPR_CW-1){1'b0}}};

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result beat changed under stall");

  // input backs up only when a full pipe meets a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // clip flag only with a coordinate at a limit
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |->
      (out_data.out_x == C_MAX) || (out_data.out_x == C_MIN) ||
      (out_data.out_y == C_MAX) || (out_data.out_y == C_MIN) ||
      (out_data.out_z == C_MAX) || (out_data.out_z == C_MIN))
    else $error("clip flag without saturated coordinate");

  // accepted beat reaches the output when the output side keeps taking beats
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind quaternion_point_rotator qpr_checker u_qpr_checker (.*);
